[src/tfn_pkg.sv]
package tfn_pkg;

  localparam int COORD_BITS  = 16;
  localparam int NORMAL_BITS = 16;
  localparam int FRAC_BITS   = NORMAL_BITS - 2;
  localparam int EDGE_LIMIT  = 24;
  localparam int EDGE_SHIFT  = (COORD_BITS > EDGE_LIMIT) ? COORD_BITS - EDGE_LIMIT : 0;
  localparam int EDGE_W      = COORD_BITS - EDGE_SHIFT + 1;
  localparam int CROSS_W     = 2 * EDGE_W;
  localparam int MAG_W       = CROSS_W - 1;
  localparam int NORM_LEN    = 31;
  localparam int LEN_W       = $clog2(MAG_W + 1);
  localparam int CHUNKS      = (MAG_W + 7) / 8;
  localparam int SUM_W       = 2 * NORM_LEN + 2;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int NUM_W       = FRAC_BITS + ROOT_W;
  localparam int QUO_W       = FRAC_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] v0_x;
    logic signed [COORD_BITS-1:0] v0_y;
    logic signed [COORD_BITS-1:0] v0_z;
    logic signed [COORD_BITS-1:0] v1_x;
    logic signed [COORD_BITS-1:0] v1_y;
    logic signed [COORD_BITS-1:0] v1_z;
    logic signed [COORD_BITS-1:0] v2_x;
    logic signed [COORD_BITS-1:0] v2_y;
    logic signed [COORD_BITS-1:0] v2_z;
    logic                         end_of_mesh;
  } in_word_t;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic                          degenerate;
    logic                          mesh_done;
  } out_word_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] e1_x;
    logic signed [EDGE_W-1:0] e1_y;
    logic signed [EDGE_W-1:0] e1_z;
    logic signed [EDGE_W-1:0] e2_x;
    logic signed [EDGE_W-1:0] e2_y;
    logic signed [EDGE_W-1:0] e2_z;
    logic                     mesh;
  } edge_word_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       deg;
    logic       mesh;
  } tag_t;

endpackage

[src/tfn_front.sv]
module tfn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tfn_pkg::in_word_t   in_word,
  input  logic                full,
  output logic                busy,
  output logic                push,
  output tfn_pkg::edge_word_t push_word
);
  import tfn_pkg::*;

  logic       fv;
  edge_word_t ew;

  function automatic logic signed [EDGE_W-1:0] edge_of(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] m;
    logic [COORD_BITS:0] ms;
    d  = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m  = d[COORD_BITS] ? -d : d;
    ms = m >> EDGE_SHIFT;
    return d[COORD_BITS] ? -EDGE_W'(ms) : EDGE_W'(ms);
  endfunction

  assign busy      = fv && full;
  assign push      = fv && !full;
  assign push_word = ew;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (start && !busy) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
    if (start && !busy) begin
      ew.e1_x <= edge_of(in_word.v0_x, in_word.v1_x);
      ew.e1_y <= edge_of(in_word.v0_y, in_word.v1_y);
      ew.e1_z <= edge_of(in_word.v0_z, in_word.v1_z);
      ew.e2_x <= edge_of(in_word.v2_x, in_word.v1_x);
      ew.e2_y <= edge_of(in_word.v2_y, in_word.v1_y);
      ew.e2_z <= edge_of(in_word.v2_z, in_word.v1_z);
      ew.mesh <= in_word.end_of_mesh;
    end
  end

endmodule

[src/tfn_queue.sv]
module tfn_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tfn_pkg::edge_word_t push_word,
  output logic                full,
  output logic                pop,
  output tfn_pkg::edge_word_t pop_word
);
  import tfn_pkg::*;

  edge_word_t slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full     = cnt == 2'd2;
  assign pop      = cnt != 2'd0;
  assign pop_word = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      slot[wp] <= push_word;
    end
  end

endmodule

[src/tfn_back.sv]
module tfn_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop,
  input  tfn_pkg::edge_word_t pop_word,
  output logic                done,
  output tfn_pkg::out_word_t  out_word
);
  import tfn_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]            rem;
    logic [ROOT_W-1:0]           root;
    logic [SUM_W-1:0]            s;
    logic [2:0][NORM_LEN-1:0]    a;
    tag_t                        tag;
  } sqrt_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [NUM_W-1:0]  n;
    logic [QUO_W-1:0]  q;
  } lane_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  r;
    lane_t [2:0]        ln;
    tag_t               tag;
  } div_t;

  logic                          v_p, v_c, v_l, v_n, v_a, v_q, v_s;
  logic signed [CROSS_W-1:0]     p [6];
  logic                          p_mesh;
  logic [2:0][MAG_W-1:0]         cm;
  tag_t                          c_tag;
  logic [CHUNKS-1:0]             l_nz;
  logic [CHUNKS-1:0][3:0]        l_len;
  logic [2:0][MAG_W-1:0]         l_m;
  tag_t                          l_tag;
  logic [LEN_W-1:0]              n_len;
  logic [2:0][MAG_W-1:0]         n_m;
  tag_t                          n_tag;
  logic [2:0][NORM_LEN-1:0]      a_a;
  tag_t                          a_tag;
  logic [2:0][2*NORM_LEN-1:0]    q_sq;
  logic [2:0][NORM_LEN-1:0]      q_a;
  tag_t                          q_tag;
  logic [SUM_W-1:0]              s_sum;
  logic [2:0][NORM_LEN-1:0]      s_a;
  tag_t                          s_tag;
  sqrt_t                         sq_in;
  sqrt_t                         sq [1:ROOT_W];
  logic                          sv [1:ROOT_W];
  div_t                          dv_in;
  div_t                          dq [0:QUO_W];
  logic                          dvv [0:QUO_W];

  logic signed [CROSS_W-1:0]     cx [3];
  logic [2:0][MAG_W-1:0]         cm_next;
  logic [CHUNKS*8-1:0]           orw;
  logic [CHUNKS-1:0]             nz_next;
  logic [CHUNKS-1:0][3:0]        len_next;
  logic [LEN_W-1:0]              nl_next;
  logic [2:0][NORM_LEN-1:0]      a_next;
  logic [MAG_W+NORM_LEN-1:0]     wide;

  always_comb begin
    cx[0] = p[0] - p[1];
    cx[1] = p[2] - p[3];
    cx[2] = p[4] - p[5];
    for (int i = 0; i < 3; i++) begin
      cm_next[i] = cx[i][CROSS_W-1] ? MAG_W'(-cx[i]) : MAG_W'(cx[i]);
    end
  end

  always_comb begin
    orw = (CHUNKS*8)'(cm[0] | cm[1] | cm[2]);
    for (int j = 0; j < CHUNKS; j++) begin
      nz_next[j]  = orw[j*8 +: 8] != 8'd0;
      len_next[j] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        if (orw[j*8+b]) begin
          len_next[j] = 4'(b + 1);
        end
      end
    end
  end

  always_comb begin
    nl_next = '0;
    for (int j = 0; j < CHUNKS; j++) begin
      if (l_nz[j]) begin
        nl_next = LEN_W'(j * 8) + LEN_W'(l_len[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide      = {n_m[i], {NORM_LEN{1'b0}}} >> n_len;
      a_next[i] = wide[NORM_LEN-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
      v_c <= 1'b0;
      v_l <= 1'b0;
      v_n <= 1'b0;
      v_a <= 1'b0;
      v_q <= 1'b0;
      v_s <= 1'b0;
    end else begin
      v_p <= pop;
      v_c <= v_p;
      v_l <= v_c;
      v_n <= v_l;
      v_a <= v_n;
      v_q <= v_a;
      v_s <= v_q;
    end
    p[0]   <= pop_word.e2_y * pop_word.e1_z;
    p[1]   <= pop_word.e2_z * pop_word.e1_y;
    p[2]   <= pop_word.e2_z * pop_word.e1_x;
    p[3]   <= pop_word.e2_x * pop_word.e1_z;
    p[4]   <= pop_word.e2_x * pop_word.e1_y;
    p[5]   <= pop_word.e2_y * pop_word.e1_x;
    p_mesh <= pop_word.mesh;
    cm         <= cm_next;
    c_tag.neg  <= {cx[2][CROSS_W-1], cx[1][CROSS_W-1], cx[0][CROSS_W-1]};
    c_tag.deg  <= cm_next == '0;
    c_tag.mesh <= p_mesh;
    l_nz  <= nz_next;
    l_len <= len_next;
    l_m   <= cm;
    l_tag <= c_tag;
    n_len <= nl_next;
    n_m   <= l_m;
    n_tag <= l_tag;
    a_a   <= a_next;
    a_tag <= n_tag;
    for (int i = 0; i < 3; i++) begin
      q_sq[i] <= a_a[i] * a_a[i];
    end
    q_a   <= a_a;
    q_tag <= a_tag;
    s_sum <= SUM_W'(q_sq[0]) + SUM_W'(q_sq[1]) + SUM_W'(q_sq[2]);
    s_a   <= q_a;
    s_tag <= q_tag;
  end

  always_comb begin
    sq_in.rem  = '0;
    sq_in.root = '0;
    sq_in.s    = s_sum;
    sq_in.a    = s_a;
    sq_in.tag  = s_tag;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    sqrt_t            src;
    logic             src_v;
    logic [REM_W-1:0] rsh;
    logic [REM_W-1:0] trial;
    logic             ge;
    if (k == 0) begin : g_first
      assign src   = sq_in;
      assign src_v = v_s;
    end else begin : g_rest
      assign src   = sq[k];
      assign src_v = sv[k];
    end
    assign rsh   = {src.rem[REM_W-3:0], src.s[SUM_W-1 -: 2]};
    assign trial = {1'b0, src.root, 2'b01};
    assign ge    = rsh >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= src_v;
      end
      sq[k+1].rem  <= ge ? rsh - trial : rsh;
      sq[k+1].root <= {src.root[ROOT_W-2:0], ge};
      sq[k+1].s    <= src.s << 2;
      sq[k+1].a    <= src.a;
      sq[k+1].tag  <= src.tag;
    end
  end

  always_comb begin
    dv_in.r   = sq[ROOT_W].root;
    dv_in.tag = sq[ROOT_W].tag;
    for (int i = 0; i < 3; i++) begin
      dv_in.ln[i].n   = (NUM_W'(sq[ROOT_W].a[i]) << FRAC_BITS)
                        + NUM_W'(sq[ROOT_W].root[ROOT_W-1:1]);
      dv_in.ln[i].rem = ROOT_W'(dv_in.ln[i].n[NUM_W-1:FRAC_BITS+1]);
      dv_in.ln[i].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else begin
      dvv[0] <= sv[ROOT_W];
    end
    dq[0] <= dv_in;
  end

  for (genvar d = 0; d < QUO_W; d++) begin : g_div
    div_t dn;
    always_comb begin
      logic [ROOT_W:0] rsh;
      logic            ge;
      dn = dq[d];
      for (int i = 0; i < 3; i++) begin
        rsh = {dq[d].ln[i].rem, dq[d].ln[i].n[FRAC_BITS]};
        ge  = rsh >= {1'b0, dq[d].r};
        dn.ln[i].rem = ge ? ROOT_W'(rsh - {1'b0, dq[d].r}) : ROOT_W'(rsh);
        dn.ln[i].n   = dq[d].ln[i].n << 1;
        dn.ln[i].q   = {dq[d].ln[i].q[QUO_W-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[d+1] <= 1'b0;
      end else begin
        dvv[d+1] <= dvv[d];
      end
      dq[d+1] <= dn;
    end
  end

  function automatic logic [NORMAL_BITS-1:0] place(
    input logic [QUO_W-1:0] q,
    input logic             neg,
    input logic             deg
  );
    logic [NORMAL_BITS-1:0] w;
    w = NORMAL_BITS'(q);
    if (deg) begin
      return '0;
    end
    return neg ? -w : w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvv[QUO_W];
    end
    out_word.normal_x   <= place(dq[QUO_W].ln[0].q, dq[QUO_W].tag.neg[0], dq[QUO_W].tag.deg);
    out_word.normal_y   <= place(dq[QUO_W].ln[1].q, dq[QUO_W].tag.neg[1], dq[QUO_W].tag.deg);
    out_word.normal_z   <= place(dq[QUO_W].ln[2].q, dq[QUO_W].tag.neg[2], dq[QUO_W].tag.deg);
    out_word.degenerate <= dq[QUO_W].tag.deg;
    out_word.mesh_done  <= dq[QUO_W].tag.mesh;
  end

`ifndef NO_ASSERTIONS
  localparam logic signed [NORMAL_BITS-1:0] UNIT = NORMAL_BITS'(1 << FRAC_BITS);

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_word.degenerate |->
      out_word.normal_x == 0 && out_word.normal_y == 0 && out_word.normal_z == 0)
    else $error("degenerate word carries nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> out_word.normal_x <= UNIT && out_word.normal_x >= -UNIT &&
             out_word.normal_y <= UNIT && out_word.normal_y >= -UNIT &&
             out_word.normal_z <= UNIT && out_word.normal_z >= -UNIT)
    else $error("normal component beyond unit");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule

[src/triangle_face_normal.sv]
// Channel  Handshake        Word
// input    start / busy     in_word  (three Q8.8 vertices, end_of_mesh)
// result   done (strobe)    out_word (Q1.14 unit normal, degenerate, mesh_done)
//
// One triangle per cycle sustained. The square root resolves one bit per stage (32 stages)
// and the divider one quotient bit per stage (15 stages).
// Synchronous reset empties the front register, queue and pipeline.
// The result side cannot stall; busy rises only if the two-word queue fills.
module triangle_face_normal (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tfn_pkg::in_word_t  in_word,
  output logic               busy,
  output logic               done,
  output tfn_pkg::out_word_t out_word
);
  import tfn_pkg::*;

  logic       push;
  logic       full;
  logic       pop;
  edge_word_t push_word;
  edge_word_t pop_word;

  tfn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_word   (in_word),
    .full      (full),
    .busy      (busy),
    .push      (push),
    .push_word (push_word)
  );

  tfn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .pop_word  (pop_word)
  );

  tfn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .pop_word (pop_word),
    .done     (done),
    .out_word (out_word)
  );

endmodule
